// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cbts_pkg.sv =====
// Types, widths and the candidate table of the CAN bit timing search.
package cbts_pkg;

   localparam int CLK_W   = 28;
   localparam int RATE_W  = 23;
   localparam int DIV_W   = 28;
   localparam int PRE_W   = 8;
   localparam int SEG_W   = 3;
   localparam int PROP_W  = 3;
   localparam int PHASE_W = 4;
   localparam int Q_W     = 5;

   localparam logic [PROP_W-1:0]  PROP_FIRST  = 3'd1;
   localparam logic [PROP_W-1:0]  PROP_LAST   = 3'd7;
   localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd8;

   localparam logic [Q_W-1:0] QUANTA_MIN  = 5'd11;
   localparam logic [Q_W-1:0] QUANTA_MAX  = 5'd21;
   localparam logic [9:0]     RATIO_SCALE = 10'd100;
   localparam logic [9:0]     RATIO_MIN   = 10'd20;
   localparam logic [9:0]     RATIO_MAX   = 10'd25;

   typedef enum logic {
      DIV_PRESCALE,
      DIV_ACTUAL
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_d;
      logic        eval;
      logic        step;
      logic        out_load;
   } cbts_cmd_type;

   typedef struct packed {
      logic cand_ok;
      logic last_cand;
      logic div_done;
      logic d_ok;
   } cbts_stat_type;

   // Time quanta per bit: sync + prop + two phase segments.
   function automatic logic [Q_W-1:0] quanta(input logic [PROP_W-1:0] prop,
                                             input logic [PHASE_W-1:0] phase);
      quanta = 5'd1 + {2'b00, prop} + {phase, 1'b0};
   endfunction

   // Quanta window and sample point ratio; floor(phase*100/q) in 20..25 is
   // phase*100 >= 20*q and phase*100 < 26*q.
   function automatic logic cand_valid(input logic [PROP_W-1:0] prop,
                                       input logic [PHASE_W-1:0] phase);
      logic [Q_W-1:0] q;
      logic [9:0]     scaled;
      logic [9:0]     q10;
      q      = quanta(prop, phase);
      q10    = {5'b00000, q};
      scaled = {6'b000000, phase} * RATIO_SCALE;
      cand_valid = (q >= QUANTA_MIN) && (q <= QUANTA_MAX)
                && (scaled >= RATIO_MIN * q10)
                && (scaled < (RATIO_MAX + 10'd1) * q10);
   endfunction

endpackage

// ===== rtl/cbts_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module cbts_div
   import cbts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   shifted;
   logic [DIV_W:0]   trial;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         // keep the trial difference when it does not borrow
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/cbts_datapath.sv =====
// Candidate counters, divider operands, best-candidate tracking and result register.
module cbts_datapath
   import cbts_pkg::*;
#(
   parameter int MAX_PRESCALER = 255
)(
   input  logic               clock,
   input  logic               reset,
   input  cbts_cmd_type       cmd,
   output cbts_stat_type      stat,
   input  logic [CLK_W-1:0]   clock_hz,
   input  logic [RATE_W-1:0]  bit_rate,
   output logic [PRE_W-1:0]   prescaler_div,
   output logic [SEG_W-1:0]   prop_segment,
   output logic [SEG_W-1:0]   phase_segment,
   output logic [CLK_W-1:0]   rate_error,
   output logic               found
);

   // prescaler values up to MAX_PRESCALER + 1 enter the second product
   localparam int D_W  = $clog2(MAX_PRESCALER + 2);
   localparam int DQ_W = D_W + Q_W;
   localparam logic [DIV_W-1:0] D_LIMIT = DIV_W'(MAX_PRESCALER + 1);

   logic [CLK_W-1:0]   clock_hz_ff;
   logic [RATE_W-1:0]  bit_rate_ff;
   logic [PROP_W-1:0]  prop_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [DIV_W-1:0]   d_ff;
   logic               have_ff;
   logic [CLK_W-1:0]   best_err_ff;
   logic [PRE_W-1:0]   best_pre_ff;
   logic [SEG_W-1:0]   best_prop_ff;
   logic [SEG_W-1:0]   best_phase_ff;
   logic [PRE_W-1:0]   rsp_pre_ff;
   logic [SEG_W-1:0]   rsp_prop_ff;
   logic [SEG_W-1:0]   rsp_phase_ff;
   logic [CLK_W-1:0]   rsp_err_ff;
   logic               rsp_found_ff;

   logic [Q_W-1:0]     q;
   logic [DIV_W-1:0]   rate_q;
   logic [DQ_W-1:0]    d_q;
   logic [DIV_W-1:0]   divisor;
   logic               div_done;
   logic [DIV_W-1:0]   quotient;
   logic [CLK_W-1:0]   rate_ext;
   logic [CLK_W-1:0]   err;
   logic               better;

   assign q      = quanta(prop_ff, phase_ff);
   assign rate_q = DIV_W'(bit_rate_ff) * DIV_W'(q);
   assign d_q    = DQ_W'(d_ff[D_W-1:0]) * DQ_W'(q);
   assign divisor = (cmd.div_sel == DIV_PRESCALE) ? rate_q : DIV_W'(d_q);

   cbts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (clock_hz_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rate_ext = CLK_W'(bit_rate_ff);
   assign err      = (quotient > rate_ext) ? (quotient - rate_ext) : (rate_ext - quotient);
   assign better   = !have_ff || (err < best_err_ff);

   assign stat.cand_ok   = cand_valid(prop_ff, phase_ff) && (bit_rate_ff != '0);
   assign stat.last_cand = (prop_ff == PROP_LAST) && (phase_ff == PHASE_LAST);
   assign stat.div_done  = div_done;
   assign stat.d_ok      = (d_ff != '0) && (d_ff <= D_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff      <= 1'b0;
         rsp_found_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            have_ff <= 1'b0;
         end else if (cmd.eval && better) begin
            have_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_found_ff <= have_ff;
         end
      end

      if (cmd.load) begin
         clock_hz_ff   <= clock_hz;
         bit_rate_ff   <= bit_rate;
         prop_ff       <= PROP_FIRST;
         phase_ff      <= PHASE_FIRST;
         best_err_ff   <= '0;
         best_pre_ff   <= '0;
         best_prop_ff  <= '0;
         best_phase_ff <= '0;
      end else begin
         if (cmd.step) begin
            if (phase_ff == PHASE_LAST) begin
               phase_ff <= PHASE_FIRST;
               prop_ff  <= prop_ff + 1'b1;
            end else begin
               phase_ff <= phase_ff + 1'b1;
            end
         end
         if (cmd.eval && better) begin
            best_err_ff   <= err;
            best_pre_ff   <= PRE_W'(d_ff - 1'b1);
            best_prop_ff  <= SEG_W'(prop_ff - 1'b1);
            best_phase_ff <= SEG_W'(phase_ff - 1'b1);
         end
      end

      if (cmd.latch_d) begin
         d_ff <= quotient;
      end

      if (cmd.out_load) begin
         rsp_pre_ff   <= best_pre_ff;
         rsp_prop_ff  <= best_prop_ff;
         rsp_phase_ff <= best_phase_ff;
         rsp_err_ff   <= best_err_ff;
      end
   end

   assign prescaler_div = rsp_pre_ff;
   assign prop_segment  = rsp_prop_ff;
   assign phase_segment = rsp_phase_ff;
   assign rate_error    = rsp_err_ff;
   assign found         = rsp_found_ff;

endmodule

// ===== rtl/cbts_ctrl.sv =====
// Sequencer of the bit timing search and owner of the handshakes.
module cbts_ctrl
   import cbts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  cbts_stat_type stat,
   output cbts_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_WAIT_PRE,
      ST_CHECK,
      ST_WAIT_ACT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (stat.cand_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_PRESCALE;
               state_in      = ST_WAIT_PRE;
            end else if (stat.last_cand) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_WAIT_PRE: begin
            if (stat.div_done) begin
               cmd.latch_d = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.d_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_ACTUAL;
               state_in      = ST_WAIT_ACT;
            end else if (stat.last_cand) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_CAND;
            end
         end
         ST_WAIT_ACT: begin
            if (stat.div_done) begin
               cmd.eval = 1'b1;
               if (stat.last_cand) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.step = 1'b1;
                  state_in = ST_CAND;
               end
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

// ===== rtl/can_bit_timing_search.sv =====
// Top level of the CAN bit timing search: controller, datapath and stream ports.
//
//   channel   direction   contents
//   req       in          clock_hz, bit_rate
//   rsp       out         prescaler_div, prop_segment, phase_segment, rate_error; found
//
// Search: each word walks the segment pairs in order; a pair that passes the quanta
//   and sample point window starts a prescaler division, and a pair whose prescaler
//   then fits starts a division for the actual rate. Each divider job loads its
//   operands and then forms the 28 quotient bits one after another. Only four
//   pairs pass the window.
// Reset: synchronous, active high; clears the sequencer and the result valid flag.
// Stalls: a finished result waits in the output register while the next request
//   word is already taken and searched; only the hand-over of a second result waits.
module can_bit_timing_search
   import cbts_pkg::*;
#(
   parameter int MAX_PRESCALER = 255
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // clock_hz[27:0], bit_rate[50:28], zero pad[55:51]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // prescaler_div[7:0], prop_segment[10:8],
                                    // phase_segment[13:11], rate_error[41:14], zero[47:42]
   output logic [0:0]  rsp_tuser    // found[0]
);

   cbts_cmd_type      cmd;
   cbts_stat_type     stat;
   logic [PRE_W-1:0]  prescaler_div;
   logic [SEG_W-1:0]  prop_segment;
   logic [SEG_W-1:0]  phase_segment;
   logic [CLK_W-1:0]  rate_error;
   logic              found;

   // Sequence the search over every segment pair, one divider job at a time.
   cbts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold the operands, run the divisions and keep the first smallest error.
   cbts_datapath #(
      .MAX_PRESCALER (MAX_PRESCALER)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .clock_hz      (req_tdata[CLK_W-1:0]),
      .bit_rate      (req_tdata[CLK_W+RATE_W-1:CLK_W]),
      .prescaler_div (prescaler_div),
      .prop_segment  (prop_segment),
      .phase_segment (phase_segment),
      .rate_error    (rate_error),
      .found         (found)
   );

   // Pack the result word, lowest field first; pad the top to a whole byte.
   assign rsp_tdata = {6'b000000, rate_error, phase_segment, prop_segment, prescaler_div};
   assign rsp_tuser = found;

endmodule

// ===== rtl/cbts_checker.sv =====
// Port-level checks of the CAN bit timing search, bound to the top level.
`include "assert_macros.svh"

module cbts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result word holds its contents
   `ASSERT_CLKD(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "rsp word dropped or changed under stall")

   // no result comes out of reset
   `ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   // a taken request keeps the block busy for the search
   `ASSERT_CLKD(a_req_busy, clock, reset, req_tvalid && req_tready |=> !req_tready,
      "request taken while searching")

   // an empty search reports all-zero fields
   `ASSERT_CLKD(a_none_zero, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 48'd0,
      "non-zero fields without a match")

   // a match has propagation 1..7 and phase 2..8
   `ASSERT_CLKD(a_seg_range, clock, reset,
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[10:8] != 3'd7 && rsp_tdata[13:11] != 3'd0,
      "segment out of range")

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (.*);

// ===== test/cbts_checker.sv =====
`timescale 1ns / 1ps
// Checker for the CAN bit timing search: predicts each result word and compares it.
module cbts_scoreboard
   import cbts_pkg::*;
#(
   parameter int MAX_PRESCALER = 255
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [0:0]  rsp_tuser,
   output int          mismatch_count,
   output int          pending,
   output int          checked,
   output int          found_seen
);

   typedef struct packed {
      logic               found;
      logic [27:0]        rate_error;
      logic [SEG_W-1:0]   phase_segment;
      logic [SEG_W-1:0]   prop_segment;
      logic [PRE_W-1:0]   prescaler_div;
   } timing_type;

   timing_type timing_q[$];

   // Walk every segment pair in order and keep the first strictly smallest error.
   function automatic timing_type search_timing(input logic [CLK_W-1:0]  clk_hz,
                                                input logic [RATE_W-1:0] rate);
      timing_type  best;
      logic [63:0] q, ratio, div, actual, err, best_err;
      logic        have;
      logic        usable;
      best     = '0;
      best_err = '0;
      have     = 1'b0;
      for (int p = 1; p <= 7; p++) begin
         for (int ph = 2; ph <= 8; ph++) begin
            q      = 64'(1 + p + 2 * ph);
            ratio  = (64'(ph) * 64'(RATIO_SCALE)) / q;
            usable = (q >= 64'(QUANTA_MIN)) && (q <= 64'(QUANTA_MAX))
                  && (ratio >= 64'(RATIO_MIN)) && (ratio <= 64'(RATIO_MAX))
                  && (rate != '0);
            div = '0;
            if (usable) begin
               div    = 64'(clk_hz) / (64'(rate) * q);
               usable = (div != 0) && (div - 64'd1 <= 64'(MAX_PRESCALER));
            end
            if (usable) begin
               actual = 64'(clk_hz) / (div * q);
               err    = (actual > 64'(rate)) ? actual - 64'(rate) : 64'(rate) - actual;
               if (!have || err < best_err) begin
                  have                = 1'b1;
                  best_err            = err;
                  best.prescaler_div  = PRE_W'(div - 64'd1);
                  best.prop_segment   = SEG_W'(p - 1);
                  best.phase_segment  = SEG_W'(ph - 1);
                  best.rate_error     = 28'(err);
               end
            end
         end
      end
      best.found = have;
      return best;
   endfunction

   always @(posedge clock) begin
      timing_type want, got;
      if (!reset) begin
         // Compare the result word first, so a same-edge request cannot pair with it.
         if (rsp_tvalid && rsp_tready) begin
            got.prescaler_div = rsp_tdata[7:0];
            got.prop_segment  = rsp_tdata[10:8];
            got.phase_segment = rsp_tdata[13:11];
            got.rate_error    = rsp_tdata[41:14];
            got.found         = rsp_tuser[0];
            checked++;
            if (got.found) found_seen++;
            if (timing_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result word with nothing expected: ",
                            "pre %0d prop %0d phase %0d err %0d found %0d"},
                           got.prescaler_div, got.prop_segment, got.phase_segment,
                           got.rate_error, got.found);
            end else begin
               want = timing_q.pop_front();
               if (got.prescaler_div !== want.prescaler_div
                   || got.prop_segment !== want.prop_segment
                   || got.phase_segment !== want.phase_segment
                   || got.rate_error !== want.rate_error
                   || got.found !== want.found
                   || rsp_tdata[47:42] !== 6'd0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected pre %0d prop %0d phase %0d err %0d ",
                               "found %0d, got pre %0d prop %0d phase %0d err %0d ",
                               "found %0d pad %0h"},
                              want.prescaler_div, want.prop_segment, want.phase_segment,
                              want.rate_error, want.found,
                              got.prescaler_div, got.prop_segment, got.phase_segment,
                              got.rate_error, got.found, rsp_tdata[47:42]);
               end
            end
         end
         if (req_tvalid && req_tready)
            timing_q.push_back(search_timing(req_tdata[27:0], req_tdata[50:28]));
         pending = timing_q.size();
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the CAN bit timing search testbench: clock, reset, stimulus and verdict.
module testbench;
   import cbts_pkg::*;

   localparam int MAX_PRESCALER = 255;
   // The idle limit allows many times the longest search, plus stalls.
   localparam int IDLE_LIMIT    = 8000;
   localparam int DRAIN_CYCLES  = 1300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // clock_hz[27:0], bit_rate[50:28], zero[55:51]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // prescaler_div[7:0], prop_segment[10:8],
                                   // phase_segment[13:11], rate_error[41:14], zero[47:42]
   logic [0:0]  rsp_tuser;         // found[0]

   int mismatch_count, pending, checked, found_seen;
   int words_sent = 0;
   int idle_cycles = 0;
   bit req_burst = 1'b0;           // sender sends back to back while set
   bit rsp_burst = 1'b0;           // receiver never stalls while set

   can_bit_timing_search #(.MAX_PRESCALER(MAX_PRESCALER)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cbts_scoreboard #(.MAX_PRESCALER(MAX_PRESCALER)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending        (pending),
      .checked        (checked),
      .found_seen     (found_seen)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Drop the run once nothing has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Receiver: draw a stall for every result word, hold ready low through it,
   // then keep ready high until the word is taken.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Send one request word: wait the drawn gap, present the word, hold it until
   // taken. Enter and leave at a falling edge; valid stays high between
   // back-to-back words so it is never lowered and raised in one step.
   task automatic push_request(input logic [CLK_W-1:0] clk_hz, input logic [RATE_W-1:0] rate);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, rate, clk_hz};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // Build a request that a real set-up would make: a common module clock and a
   // rate close to clock / (quanta * prescaler), so that a timing is usually found.
   task automatic push_plausible();
      longint clk_hz, rate, q, pre;
      case ($urandom_range(0, 12))
         0:  clk_hz = 8000000;
         1:  clk_hz = 16000000;
         2:  clk_hz = 20000000;
         3:  clk_hz = 24000000;
         4:  clk_hz = 40000000;
         5:  clk_hz = 48000000;
         6:  clk_hz = 60000000;
         7:  clk_hz = 80000000;
         8:  clk_hz = 100000000;
         9:  clk_hz = 120000000;
         10: clk_hz = 160000000;
         11: clk_hz = 200000000;
         default: clk_hz = $urandom_range(1000000, 200000000);
      endcase
      q    = $urandom_range(12, 21);
      pre  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 32) : $urandom_range(1, 260);
      rate = clk_hz / (q * pre) + longint'($urandom_range(0, 6)) - 3;
      if (rate < 1) rate = 1;
      if (rate > 64'h7FFFFF) rate = 64'h7FFFFF;
      push_request(CLK_W'(clk_hz), RATE_W'(rate));
   endtask

   // Noise and awkward corners: raw random fields, zeros, clock below rate,
   // prescaler far out of range.
   task automatic push_noise();
      case ($urandom_range(0, 5))
         0, 1: push_request(CLK_W'($urandom), RATE_W'($urandom));
         2:    push_request(CLK_W'($urandom), '0);
         3:    push_request('0, RATE_W'($urandom));
         4:    push_request(CLK_W'($urandom_range(1, 1000)),
                            RATE_W'($urandom_range(1001, 8000000)));
         default: push_request(CLK_W'($urandom_range(100000000, 268435455)),
                               RATE_W'($urandom_range(1, 200)));
      endcase
   endtask

   initial begin
      int directed;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, nothing found, prescaler limits, usual rates.
      push_request('0, '0);                            // zero clock and zero rate
      push_request('0, 23'd500000);                    // zero clock
      push_request(28'd40000000, '0);                  // zero bit rate
      push_request(28'd1, 23'd1);                      // clock too slow for any quanta
      push_request(28'hFFFFFFF, 23'h7FFFFF);           // all ones
      push_request(28'hFFFFFFF, 23'd1);                // prescaler far above its limit
      push_request(28'h8000000, 23'h400000);           // top bits alone
      push_request(28'd200000000, 23'd8000000);
      push_request(28'd200000000, 23'd1000000);
      push_request(28'd8000000, 23'd8000000);          // nothing found
      push_request(28'd40000000, 23'd500000);
      push_request(28'd80000000, 23'd1000000);
      push_request(28'd16000000, 23'd125000);
      push_request(28'd24000000, 23'd250000);
      push_request(28'd100000000, 23'd33333);
      push_request(28'd3072000, 23'd1000);             // prescaler exactly at its limit
      push_request(28'd3084000, 23'd1000);             // one past the limit for 12 quanta
      push_request(28'd12, 23'd1);                     // prescaler of one, 12 quanta
      push_request(28'h5555555, 23'h2AAAAA);
      push_request(28'hAAAAAAA, 23'h555555);
      directed = words_sent;

      // Random phases; alternate back-to-back sending and stall-free receiving.
      for (int phase = 0; phase < 5; phase++) begin
         req_burst = (phase % 2) == 1;
         rsp_burst = (phase == 1) || (phase == 4);
         for (int n = 0; n < 54; n++) begin
            if ($urandom_range(0, 9) < 8) push_plausible();
            else push_noise();
         end
      end
      req_tvalid <= 1'b0;
      rsp_burst = 1'b0;

      // Drain: wait for every expected result, then let the block settle.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request words (%0d directed), checked %0d results, %0d found.",
               words_sent, directed, checked, found_seen);
      $display("Both sides stalled 0 to 10 cycles per word, with stall-free runs; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
